>>> design/orbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package orbr_pkg;

    localparam logic MODE_PUBLISH = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    localparam int           BYTE_LANES = 8;
    localparam logic [3:0]   BYTE_MAX   = 4'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic publish;   // write the accepted word into the store
        logic capture;   // latch the reader id of an accepted read
        logic resolve;   // work out the reader position and read the slot
    } t_cmd;

endpackage

`default_nettype wire

>>> design/orbr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface orbr_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [1:0]  reader_id;
    logic [63:0] payload;
    logic [3:0]  byte_count;

    modport source (output valid, mode, reader_id, payload, byte_count, input ready);
    modport sink   (input valid, mode, reader_id, payload, byte_count, output ready);
endinterface

interface orbr_out_if;
    logic        valid;
    logic        ready;
    logic        has_message;
    logic [63:0] message_payload;
    logic [3:0]  message_byte_count;
    logic [31:0] message_position;

    modport source (output valid, has_message, message_payload, message_byte_count,
                    message_position, input ready);
    modport sink   (input valid, has_message, message_payload, message_byte_count,
                    message_position, output ready);
endinterface

`default_nettype wire

>>> design/orbr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module orbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_mode,
    input  wire logic          i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output orbr_pkg::t_cmd     o_cmd
);
    import orbr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_RESOLVE = 3'b010,
        S_OUT     = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.publish = w_accept && (i_in_mode == MODE_PUBLISH);
        o_cmd.capture = w_accept && (i_in_mode == MODE_READ);
        o_cmd.resolve = (r_state == S_RESOLVE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_mode == MODE_READ)) n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/orbr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module orbr_dpath #(
    parameter int DEPTH   = 16,
    parameter int READERS = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire orbr_pkg::t_cmd i_cmd,
    input  wire logic [1:0]     i_reader_id,
    input  wire logic [63:0]    i_payload,
    input  wire logic [3:0]     i_byte_count,
    output logic                o_has_message,
    output logic [63:0]         o_message_payload,
    output logic [3:0]          o_message_byte_count,
    output logic [31:0]         o_message_position
);
    import orbr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam logic [31:0]   DEPTH_W        = 32'(DEPTH);
    localparam logic [31:0]   BACK_W         = 32'(DEPTH - 1);
    localparam logic [31:0]   READERS_W      = 32'(READERS);
    localparam logic [AW-1:0] SLOT_LAST      = AW'(DEPTH - 1);
    // the first oldest position after the store fills is always 2
    localparam logic [AW-1:0] OLD_FIRST_SLOT = AW'(2 % DEPTH);

    // counters and their slot indexes, kept in step to avoid a modulo
    logic [31:0]   r_wc;
    logic [AW-1:0] r_wslot;
    logic [31:0]   r_oldest;
    logic [AW-1:0] r_oslot;
    logic          r_old_live;
    logic          r_full;

    logic [31:0]   r_pos     [READERS];
    logic [AW-1:0] r_pslot   [READERS];
    logic          r_started [READERS];

    logic [1:0]    r_rid;
    logic          r_has;
    logic [31:0]   r_mpos;

    logic [63:0]   r_mem_bytes [DEPTH];
    logic [3:0]    r_mem_cnt   [DEPTH];
    logic [63:0]   r_q_bytes;
    logic [3:0]    r_q_cnt;

    // publish path
    logic [3:0]            w_cnt;
    logic [BYTE_LANES-1:0] w_be;
    logic [31:0]           w_wc_inc;
    logic [AW-1:0]         w_wslot_inc;
    logic [31:0]           w_old_inc;
    logic [AW-1:0]         w_oslot_inc;

    always_comb begin
        w_cnt = (i_byte_count > BYTE_MAX) ? BYTE_MAX : i_byte_count;
        for (int b = 0; b < BYTE_LANES; b++) begin
            w_be[b] = (4'(b) < w_cnt);
        end
        w_wc_inc    = r_wc + 32'd1;
        w_wslot_inc = ((w_wc_inc == 32'd0) || (r_wslot == SLOT_LAST))
                      ? '0 : r_wslot + AW'(1);
        w_old_inc   = w_wc_inc - BACK_W;
        w_oslot_inc = ((w_old_inc == 32'd0) || (r_oslot == SLOT_LAST))
                      ? '0 : r_oslot + AW'(1);
    end

    // read path
    logic          w_rid_ok;
    logic [RW-1:0] w_idx;
    logic [31:0]   w_wanted;
    logic          w_near;
    logic          w_hit;
    logic [31:0]   w_new_pos;
    logic [AW-1:0] w_new_slot;
    logic [AW-1:0] w_next_slot;

    always_comb begin
        w_rid_ok    = (32'(r_rid) < READERS_W);
        w_idx       = w_rid_ok ? RW'(r_rid) : '0;
        w_wanted    = r_started[w_idx] ? r_pos[w_idx] + 32'd1 : r_oldest;
        w_near      = ((r_wc - w_wanted) < DEPTH_W);
        w_hit       = w_rid_ok && (w_wanted != r_wc);
        w_new_pos   = w_near ? w_wanted : r_oldest;
        w_next_slot = ((w_wanted == 32'd0) || (r_pslot[w_idx] == SLOT_LAST))
                      ? '0 : r_pslot[w_idx] + AW'(1);
        // step the reader's slot only when it advances by one
        w_new_slot  = (r_started[w_idx] && w_near) ? w_next_slot : r_oslot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc       <= '0;
            r_wslot    <= '0;
            r_oldest   <= '0;
            r_oslot    <= '0;
            r_old_live <= 1'b0;
            r_full     <= 1'b0;
        end else if (i_cmd.publish) begin
            r_wc    <= w_wc_inc;
            r_wslot <= w_wslot_inc;
            if (r_full) begin
                r_oldest   <= w_old_inc;
                r_oslot    <= r_old_live ? w_oslot_inc : OLD_FIRST_SLOT;
                r_old_live <= 1'b1;
            end else if (w_wslot_inc == '0) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < READERS; r++) begin
                r_started[r] <= 1'b0;
            end
        end else if (i_cmd.resolve && w_hit) begin
            r_started[w_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && w_hit) begin
            r_pos[w_idx]   <= w_new_pos;
            r_pslot[w_idx] <= w_new_slot;
        end
        if (i_cmd.capture) begin
            r_rid <= i_reader_id;
        end
        if (i_cmd.resolve) begin
            r_has  <= w_hit;
            r_mpos <= w_new_pos;
        end
    end

    // slot store: byte-lane writes on publish, registered read on resolve
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            for (int b = 0; b < BYTE_LANES; b++) begin
                if (w_be[b]) r_mem_bytes[r_wslot][8*b +: 8] <= i_payload[8*b +: 8];
            end
            r_mem_cnt[r_wslot] <= w_cnt;
        end
        if (i_cmd.resolve) begin
            r_q_bytes <= r_mem_bytes[w_new_slot];
            r_q_cnt   <= r_mem_cnt[w_new_slot];
        end
    end

    assign o_has_message        = r_has;
    assign o_message_payload    = r_has ? r_q_bytes : 64'd0;
    assign o_message_byte_count = r_has ? r_q_cnt : 4'd0;
    assign o_message_position   = r_has ? r_mpos : 32'd0;

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("store full flag cleared");

    a_live_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_old_live |-> r_full)
        else $error("oldest position moved before store filled");

    a_oldest_trails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.publish && r_full) |=> (r_oldest == r_wc - BACK_W))
        else $error("oldest position does not trail write count");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.publish && (i_cmd.resolve || i_cmd.capture)))
        else $error("publish overlaps a read");

endmodule

`default_nettype wire

>>> design/overwriting_ring_buffer_readers.sv
// Publish word: written into the store at acceptance; no result.
// Read word: position resolve and registered store read share the resolve state, so the
// result is valid from the cycle after the resolve state; the next word is taken once
// the result is taken, so the block takes no new word while a read is in progress.
// Output stalls lengthen the read.
// Reset (synchronous, active low) clears counters and reader state; the slot store
// is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_ring_buffer_readers #(
    parameter int DEPTH   = 16,
    parameter int READERS = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    orbr_in_if.sink   i_in,
    orbr_out_if.source o_out
);
    import orbr_pkg::*;

    t_cmd w_cmd;

    orbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    orbr_dpath #(
        .DEPTH   (DEPTH),
        .READERS (READERS)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_reader_id          (i_in.reader_id),
        .i_payload            (i_in.payload),
        .i_byte_count         (i_in.byte_count),
        .o_has_message        (o_out.has_message),
        .o_message_payload    (o_out.message_payload),
        .o_message_byte_count (o_out.message_byte_count),
        .o_message_position   (o_out.message_position)
    );

endmodule

`default_nettype wire

>>> verif/overwriting_ring_buffer_readers_tb.sv
`timescale 1ns / 1ps

module overwriting_ring_buffer_readers_tb;
    import orbr_pkg::*;

    localparam int DEPTH   = 16;
    localparam int READERS = 4;
    localparam int RANDOM_WORDS = 950;
    localparam int CALM_TAIL    = 150;

    typedef struct packed {
        logic        has_msg;
        logic [63:0] data;
        logic [3:0]  count;
        logic [31:0] pos;
    } t_reply;

    // Mirror of the ring: slot store, write counter and reader positions,
    // plus the replies owed to the readers in order.
    class ring_mirror;
        bit [31:0] wr_count;
        bit [31:0] oldest;
        bit        wrapped;
        bit [63:0] slot_data [DEPTH];
        bit [3:0]  slot_len [DEPTH];
        bit [31:0] rd_pos [READERS];
        bit        rd_started [READERS];
        t_reply    replies_due[$];
        int        bad;

        function void take_word(logic mode, logic [1:0] rid, logic [63:0] data,
                                logic [3:0] cnt);
            t_reply    r;
            bit [3:0]  n;
            bit [63:0] mask;
            bit [31:0] want;
            int        s;
            if (mode == MODE_PUBLISH) begin
                n = (cnt > BYTE_MAX) ? BYTE_MAX : cnt;
                mask = (n == BYTE_MAX) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                s = wr_count % DEPTH;
                // bytes above the count keep what the slot held
                slot_data[s] = (slot_data[s] & ~mask) | (data & mask);
                slot_len[s] = n;
                wr_count = wr_count + 32'd1;
                if (wrapped)
                    oldest = wr_count - 32'(DEPTH - 1);
                else if (wr_count % DEPTH == 0)
                    wrapped = 1'b1;
                return;
            end
            r = '0;
            if (rid < READERS) begin
                want = rd_started[rid] ? rd_pos[rid] + 32'd1 : oldest;
                if (want != wr_count) begin
                    // a reader lapped by the writer jumps to the oldest message
                    rd_pos[rid] = (wr_count - want < 32'(DEPTH)) ? want : oldest;
                    rd_started[rid] = 1'b1;
                    s = rd_pos[rid] % DEPTH;
                    r.has_msg = 1'b1;
                    r.data    = slot_data[s];
                    r.count   = slot_len[s];
                    r.pos     = rd_pos[rid];
                end
            end
            replies_due.push_back(r);
        endfunction

        function void match_reply(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                bad++;
                if (bad <= 10)
                    $display("%0t: reply with none due: has=%0b data=%h cnt=%0d pos=%0d",
                             $realtime, got.has_msg, got.data, got.count, got.pos);
                return;
            end
            want = replies_due.pop_front();
            if (got.has_msg !== want.has_msg || got.data !== want.data ||
                got.count !== want.count || got.pos !== want.pos) begin
                bad++;
                if (bad <= 10)
                    $display("%0t: reply mismatch: exp has=%0b data=%h cnt=%0d pos=%0d, got has=%0b data=%h cnt=%0d pos=%0d",
                             $realtime, want.has_msg, want.data, want.count, want.pos,
                             got.has_msg, got.data, got.count, got.pos);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    orbr_in_if  in_bus ();
    orbr_out_if out_bus ();

    ring_mirror mirror;
    int gap_pct;
    int stall_pct;
    int stall_left;
    int words_sent;

    overwriting_ring_buffer_readers #(
        .DEPTH   (DEPTH),
        .READERS (READERS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("overwriting_ring_buffer_readers_tb: FAIL");
        $finish;
    end

    // Called at a clock edge; returns at the edge where the word is taken.
    task automatic send_word(input logic mode, input logic [1:0] rid,
                             input logic [63:0] data, input logic [3:0] cnt);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.mode       <= mode;
        in_bus.reader_id  <= rid;
        in_bus.payload    <= data;
        in_bus.byte_count <= cnt;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        mirror.take_word(mode, rid, data, cnt);
        words_sent++;
    endtask

    function automatic logic [63:0] pick_bytes();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Until every slot has taken a full word, publish at least 8 bytes so no
    // byte of the store is read before it was written.
    task automatic publish_random();
        logic [3:0] cnt;
        cnt = (mirror.wr_count < DEPTH) ? 4'($urandom_range(8, 15))
                                        : 4'($urandom_range(0, 15));
        send_word(MODE_PUBLISH, 2'($urandom), pick_bytes(), cnt);
    endtask

    // Result side: check taken replies, stall in bursts.
    initial begin
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
                mirror.match_reply({out_bus.has_message, out_bus.message_payload,
                                    out_bus.message_byte_count, out_bus.message_position});
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 10);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int k;
        int seg_len;
        int pub_pct;
        int rd_lo;
        int rd_hi;
        mirror = new();
        gap_pct = 0;
        stall_pct = 0;
        words_sent = 0;
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.mode       <= MODE_PUBLISH;
        in_bus.reader_id  <= '0;
        in_bus.payload    <= '0;
        in_bus.byte_count <= '0;
        out_bus.ready     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, first reads, caught-up reader, oversize counts,
        // store filling up, short publish over an old slot, lapped reader
        gap_pct = 15;
        stall_pct = 12;
        send_word(MODE_READ, 2'd0, '1, 4'd15);
        send_word(MODE_PUBLISH, 2'd2, '1, 4'd8);
        send_word(MODE_PUBLISH, 2'd1, '0, 4'd15);
        send_word(MODE_READ, 2'd0, '0, 4'd0);
        send_word(MODE_READ, 2'd0, '0, 4'd0);
        send_word(MODE_READ, 2'd0, '0, 4'd0);
        send_word(MODE_PUBLISH, 2'd3, 64'hA5A5_5A5A_F00F_0FF0, 4'd9);
        send_word(MODE_READ, 2'd1, '1, 4'd15);
        for (k = 0; k < 13; k++)
            send_word(MODE_PUBLISH, 2'(k), (k % 2) ? '1 : {$urandom, $urandom},
                      4'(8 + k % 8));
        send_word(MODE_READ, 2'd2, '0, 4'd0);
        send_word(MODE_PUBLISH, 2'd0, '1, 4'd0);
        send_word(MODE_READ, 2'd0, '0, 4'd0);
        send_word(MODE_READ, 2'd1, '0, 4'd0);

        // random: segments with their own publish/read mix and reader subset,
        // so some readers stay caught up and others get lapped
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: pub_pct = 10;
                1: pub_pct = 50;
                default: pub_pct = 90;
            endcase
            if ($urandom_range(0, 2) == 0) begin
                rd_lo = $urandom_range(0, 2);
                rd_hi = rd_lo + 1;
            end else begin
                rd_lo = 0;
                rd_hi = READERS - 1;
            end
            if (words_sent >= RANDOM_WORDS - CALM_TAIL) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = 15;
                stall_pct = 12;
            end
            for (k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 99) < pub_pct)
                    publish_random();
                else
                    send_word(MODE_READ, 2'($urandom_range(rd_lo, rd_hi)),
                              {$urandom, $urandom}, 4'($urandom));
            end
        end
        in_bus.valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;

        while (mirror.replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mirror.bad == 0 && mirror.replies_due.size() == 0)
            $display("overwriting_ring_buffer_readers_tb: PASS");
        else
            $display("overwriting_ring_buffer_readers_tb: FAIL");
        $finish;
    end

endmodule
